// ===== hdl/mat_pkg.sv =====
package mat_pkg;

	localparam int DIV_W     = 31;
	localparam int DIV_CNT_W = 5;

	localparam logic [11:0] HALF_TURN     = 12'd2048;
	localparam logic [15:0] CDEG_PER_TURN = 16'd36000;
	localparam logic [26:0] DISP_MAX      = 27'h7FFFFFF;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== hdl/multiturn_angle_tracker.sv =====
// Multi-turn tracker for a 12-bit absolute angle sensor. Calibration requests
// (op 0) drop the first DISCARD_COUNT samples and average the next
// AVERAGE_COUNT to set the reference; tracking requests (op 1) unwrap zero
// crossings into a saturating signed turn count and report displacement,
// direction and output-shaft angle in centidegrees for the gear ratio in
// cfg_wdata (0 acts as 1). One shared restoring divider does all division:
// a tracking request uses it twice (15 then 31 divider steps), the final
// calibration sample once (one step per bit of the sample sum), and other
// calibration samples not at all. in_stall is high while a request
// is in work; a finished result waits in the output register while the next
// request is taken.
module multiturn_angle_tracker #(
	parameter int DISCARD_COUNT = 20,
	parameter int AVERAGE_COUNT = 20,
	parameter int TURN_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [11:0]        sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               calibrated,
	output logic signed [15:0] turns,
	output logic [26:0]        displacement,
	output logic               direction,
	output logic [30:0]        total_angle,
	output logic [15:0]        turn_angle
);
	import mat_pkg::*;

	localparam int CW = $clog2(DISCARD_COUNT + AVERAGE_COUNT + 1);
	localparam int SW = $clog2(AVERAGE_COUNT * 4095 + 1);
	localparam int PW = TURN_BITS + 13;
	localparam int MW = (PW > 27) ? PW : 27;
	localparam logic signed [TURN_BITS-1:0] TURN_LIM = TURN_BITS'((1 << (TURN_BITS - 1)) - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_POS    = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_DIVQ   = 3'd3;
	localparam logic [2:0] ST_DIVT   = 3'd4;
	localparam logic [2:0] ST_CSTART = 3'd5;
	localparam logic [2:0] ST_CAL    = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	logic [2:0]                  state_q;
	logic [7:0]                  gear_q;
	logic [11:0]                 ref_q;
	logic [11:0]                 prev_q;
	logic signed [TURN_BITS-1:0] turn_q;
	logic [CW-1:0]               cnt_q;
	logic [SW-1:0]               sum_q;
	logic                        cdone_q;
	logic                        out_valid_q;

	logic        op_q;
	logic [11:0] sample_q;
	logic [26:0] disp_q;
	logic        dir_q;
	logic [30:0] x_q;
	logic [14:0] qt_q;
	logic [30:0] prod_q;
	logic [30:0] total_q;

	div_req_t         div_req;
	div_sts_t         div_sts;
	logic [DIV_W-1:0] div_dividend;
	logic [7:0]       div_divisor;
	logic [DIV_W-1:0] div_quot;

	logic [7:0] g;
	assign g = (gear_q == 8'd0) ? 8'd1 : gear_q;

	// calibration step
	logic [CW-1:0] cnt_eff;
	logic [CW-1:0] cnt_new;
	logic [SW-1:0] sum_eff;
	logic [SW-1:0] sum_new;
	logic          cal_last;

	always_comb begin
		cnt_eff  = cdone_q ? '0 : cnt_q;
		sum_eff  = cdone_q ? '0 : sum_q;
		sum_new  = (cnt_eff >= CW'(DISCARD_COUNT)) ? sum_eff + SW'(sample) : sum_eff;
		cnt_new  = cnt_eff + 1'b1;
		cal_last = cnt_new >= CW'(DISCARD_COUNT + AVERAGE_COUNT);
	end

	// tracking step
	logic signed [TURN_BITS-1:0] turn_trk;

	always_comb begin
		turn_trk = turn_q;
		if (prev_q >= sample) begin
			if ((prev_q - sample) > HALF_TURN && turn_q < TURN_LIM)
				turn_trk = turn_q + 1'b1;
		end else begin
			if ((sample - prev_q) > HALF_TURN && turn_q > -TURN_LIM)
				turn_trk = turn_q - 1'b1;
		end
	end

	// position, magnitude and saturation
	logic signed [PW-1:0] pos;
	logic [PW-1:0]        mag;
	logic [MW-1:0]        mag_ext;
	logic [26:0]          disp_sat;

	always_comb begin
		pos      = PW'(signed'({turn_q, 12'd0})) + signed'(PW'(sample_q))
		           - signed'(PW'(ref_q));
		mag      = pos[PW-1] ? PW'(-pos) : PW'(pos);
		mag_ext  = MW'(mag);
		disp_sat = (mag_ext > MW'(DISP_MAX)) ? DISP_MAX : mag_ext[26:0];
	end

	logic [42:0] xfull;
	assign xfull = 43'(disp_q) * 43'(CDEG_PER_TURN);

	logic [30:0] turn_rem;
	assign turn_rem = total_q - prod_q;

	always_comb begin
		div_req.start = 1'b0;
		div_req.steps = DIV_CNT_W'(15);
		div_dividend  = {disp_q[26:12], 16'd0};
		div_divisor   = g;
		case (state_q)
			ST_MUL: begin
				div_req.start = 1'b1;
			end
			ST_DIVQ: begin
				div_req.start = div_sts.done;
				div_req.steps = DIV_CNT_W'(DIV_W);
				div_dividend  = x_q;
			end
			ST_CSTART: begin
				div_req.start = 1'b1;
				div_req.steps = DIV_CNT_W'(SW);
				div_dividend  = DIV_W'(sum_q) << (DIV_W - SW);
				div_divisor   = 8'(AVERAGE_COUNT);
			end
			ST_CAL: begin
				div_divisor   = 8'(AVERAGE_COUNT);
			end
			default: begin
			end
		endcase
	end

	mat_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.sts      (div_sts),
		.quotient (div_quot)
	);

	assign in_stall = (state_q != ST_IDLE);

	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gear_q      <= 8'd1;
			ref_q       <= '0;
			prev_q      <= '0;
			turn_q      <= '0;
			cnt_q       <= '0;
			sum_q       <= '0;
			cdone_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen)
				gear_q <= cfg_wdata;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (op) begin
							turn_q  <= turn_trk;
							prev_q  <= sample;
							state_q <= ST_POS;
						end else if (cal_last) begin
							cnt_q   <= '0;
							sum_q   <= sum_new;
							turn_q  <= '0;
							cdone_q <= 1'b1;
							state_q <= ST_CSTART;
						end else begin
							cnt_q   <= cnt_new;
							sum_q   <= sum_new;
							if (cdone_q)
								turn_q <= '0;
							cdone_q <= 1'b0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_POS:    state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_DIVQ;
				ST_DIVQ: begin
					if (div_sts.done)
						state_q <= ST_DIVT;
				end
				ST_DIVT: begin
					if (div_sts.done)
						state_q <= ST_OUT;
				end
				ST_CSTART: state_q <= ST_CAL;
				ST_CAL: begin
					if (div_sts.done) begin
						ref_q   <= div_quot[11:0];
						prev_q  <= div_quot[11:0];
						sum_q   <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic signed [31:0] turn_w;
	assign turn_w = 32'(turn_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q     <= op;
			sample_q <= sample;
		end
		if (state_q == ST_POS) begin
			disp_q <= disp_sat;
			dir_q  <= pos[PW-1];
		end
		if (state_q == ST_MUL)
			x_q <= 31'(xfull >> 12);
		if (state_q == ST_DIVQ && div_sts.done)
			qt_q <= div_quot[14:0];
		if (state_q == ST_DIVT) begin
			prod_q <= 31'(qt_q) * 31'(CDEG_PER_TURN);
			if (div_sts.done)
				total_q <= div_quot;
		end
		if (out_load) begin
			calibrated   <= cdone_q;
			turns        <= 16'(turn_w);
			displacement <= op_q ? disp_q : 27'd0;
			direction    <= op_q ? dir_q : 1'b0;
			total_angle  <= op_q ? total_q : 31'd0;
			turn_angle   <= op_q ? 16'(turn_rem) : 16'd0;
		end
	end

	assign out_valid = out_valid_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_sts.busy)
		else $error("divider started while busy");

	a_turn_limit: assert property (@(posedge clk) disable iff (!arst_n)
		turn_q <= TURN_LIM && turn_q >= -TURN_LIM)
		else $error("turn count beyond limit");

	a_turn_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> turn_angle < CDEG_PER_TURN)
		else $error("turn angle out of range");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted without going busy");

endmodule

// ===== hdl/mat_div.sv =====
module mat_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mat_pkg::div_req_t             req,
	input  logic [mat_pkg::DIV_W-1:0]     dividend,
	input  logic [7:0]                    divisor,
	output mat_pkg::div_sts_t             sts,
	output logic [mat_pkg::DIV_W-1:0]     quotient
);
	import mat_pkg::*;

	// restoring divider, one quotient bit per cycle; dividend is left-aligned
	logic [7:0]           rem_q;
	logic [DIV_W-1:0]     dq_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [8:0] shifted;
	logic       ge;
	logic [7:0] rem_n;

	always_comb begin
		shifted = {rem_q, dq_q[DIV_W-1]};
		ge      = shifted >= {1'b0, divisor};
		rem_n   = ge ? 8'(shifted - {1'b0, divisor}) : shifted[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_n;
			dq_q  <= {dq_q[DIV_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = dq_q;

endmodule
